// File: hw/rtl/prqs_pkg.sv
// Package with the default sizes and command and status codes of the ready queue scheduler.
package prqs_pkg;

  // Default sizing handed to the top level parameters.
  localparam int ThreadsDef = 16;
  localparam int LevelsDef  = 8;

  // Fixed widths of the beat fields.
  localparam int FuncW   = 2;
  localparam int TidW    = 4;
  localparam int PrioW   = 5;
  localparam int StatusW = 3;
  localparam int CountW  = 5;

  // Command codes.
  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_SCHED  = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_PRIO = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StatusW-1:0] ST_DUP      = 3'd3;
  localparam logic [StatusW-1:0] ST_ABSENT   = 3'd4;

endpackage

// File: hw/rtl/priority_ready_queue_scheduler_unit.sv
// Top level of the priority ready queue scheduler with its thread rings and ready mask.
//
// Usage: the kernel sends one command beat on the input channel (func_i,
// thread_id_i, priority_req_i) qualified by in_valid_i and throttled by
// in_stall_o. Each command produces exactly one result beat on the output
// channel (status_o, next_thread_o, ready_count_o) qualified by out_valid_o
// and throttled by out_stall_i.
// Order: a command beat lands in the input register when it is accepted, and
// its result is then registered in the result register, from which it is
// offered on the output channel.
// Throughput: one command per cycle while the receiver does not stall. The ring
// lookups, the priority encoder over the ready mask and the table updates all
// complete combinationally between the input register and the result register.
// Reset clears the ready mask, the ring heads, the queued flags, the thread
// count and both valid flags; the link and level tables are only read for
// queued threads and need no clearing.
// When the receiver stalls, the result register holds its beat; the input
// register keeps one more command and in_stall_o rises only once both are full.
module priority_ready_queue_scheduler_unit
  import prqs_pkg::*;
#(
  parameter int THREADS         = ThreadsDef,
  parameter int PRIORITY_LEVELS = LevelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [TidW-1:0]    thread_id_i,
  input  logic [PrioW-1:0]   priority_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [TidW-1:0]    next_thread_o,
  output logic [CountW-1:0]  ready_count_o
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int CW = $clog2(THREADS + 1);

  // Input register.
  logic             in_valid_q;
  logic [FuncW-1:0] func_q;
  logic [TidW-1:0]  tid_q;
  logic [PrioW-1:0] prio_q;

  // Result register.
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [TidW-1:0]    next_thread_q;

  // Scheduler state.
  logic [TW-1:0]              level_head_q [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] ready_mask_q, ready_mask_d;
  logic [TW-1:0]              link_next_q  [THREADS];
  logic [TW-1:0]              link_prev_q  [THREADS];
  logic [LW-1:0]              thread_level_q [THREADS];
  logic [THREADS-1:0]         queued_q, queued_d;
  logic [CW-1:0]              count_q, count_d;

  // Handshake control.
  logic advance;
  logic do_work;

  assign advance    = !out_valid_q || !out_stall_i;
  assign do_work    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Decoded operands.
  logic          tid_ok, prio_ok;
  logic [TW-1:0] tid_ix;
  logic [LW-1:0] prio_ix;

  assign tid_ok  = 32'(tid_q) < 32'(THREADS);
  assign prio_ok = 32'(prio_q) < 32'(PRIORITY_LEVELS);
  assign tid_ix  = TW'(tid_q);
  assign prio_ix = LW'(prio_q);

  // Lowest set bit of the ready mask is the highest ready level.
  logic          any_ready;
  logic [LW-1:0] top_lvl;

  always_comb begin
    any_ready = 1'b0;
    top_lvl   = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (ready_mask_q[i]) begin
        any_ready = 1'b1;
        top_lvl   = LW'(i);
      end
    end
  end

  // Ring neighbors used by the commands.
  logic [TW-1:0] add_head, add_tail;
  logic [TW-1:0] rm_prv, rm_nxt;
  logic [LW-1:0] rm_lvl;
  logic [TW-1:0] sch_head;

  assign add_head = level_head_q[prio_ix];
  assign add_tail = link_prev_q[add_head];
  assign rm_prv   = link_prev_q[tid_ix];
  assign rm_nxt   = link_next_q[tid_ix];
  assign rm_lvl   = thread_level_q[tid_ix];
  assign sch_head = level_head_q[top_lvl];

  // Update commands for the tables.
  logic [StatusW-1:0] status_d;
  logic [TW-1:0]      chosen_d;
  logic               head_we;
  logic [LW-1:0]      head_a;
  logic [TW-1:0]      head_wd;
  logic               lvl_we;
  logic               nx_we0, nx_we1, pv_we0, pv_we1;
  logic [TW-1:0]      nx_a0, nx_d0, nx_a1, nx_d1;
  logic [TW-1:0]      pv_a0, pv_d0, pv_a1, pv_d1;

  always_comb begin
    status_d     = ST_OK;
    chosen_d     = '0;
    ready_mask_d = ready_mask_q;
    queued_d     = queued_q;
    count_d      = count_q;
    head_we      = 1'b0;
    head_a       = prio_ix;
    head_wd      = tid_ix;
    lvl_we       = 1'b0;
    nx_we0       = 1'b0;
    nx_we1       = 1'b0;
    pv_we0       = 1'b0;
    pv_we1       = 1'b0;
    nx_a0        = tid_ix;
    nx_d0        = tid_ix;
    nx_a1        = tid_ix;
    nx_d1        = add_head;
    pv_a0        = tid_ix;
    pv_d0        = tid_ix;
    pv_a1        = add_head;
    pv_d1        = tid_ix;
    case (func_q)
      FUNC_ADD: begin
        if (!tid_ok || !prio_ok) begin
          status_d = ST_BAD_PRIO;
        end else if (queued_q[tid_ix]) begin
          status_d = ST_DUP;
        end else begin
          lvl_we           = 1'b1;
          queued_d[tid_ix] = 1'b1;
          if (count_q < CW'(THREADS)) begin
            count_d = count_q + CW'(1);
          end
          if (!ready_mask_q[prio_ix]) begin
            // First thread of this level forms a ring of its own.
            ready_mask_d[prio_ix] = 1'b1;
            head_we = 1'b1;
            nx_we0  = 1'b1;
            pv_we0  = 1'b1;
          end else begin
            // Splice the new thread in between the tail and the head.
            nx_we0 = 1'b1;
            nx_a0  = add_tail;
            nx_d0  = tid_ix;
            nx_we1 = 1'b1;
            pv_we0 = 1'b1;
            pv_d0  = add_tail;
            pv_we1 = 1'b1;
          end
        end
      end
      FUNC_REMOVE: begin
        if (!tid_ok || !queued_q[tid_ix]) begin
          status_d = ST_ABSENT;
        end else begin
          queued_d[tid_ix] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CW'(1);
          end
          head_a = rm_lvl;
          if (rm_nxt == tid_ix) begin
            // Last thread of its level: the level goes empty.
            ready_mask_d[rm_lvl] = 1'b0;
            head_we = 1'b1;
            head_wd = '0;
          end else begin
            head_we = (level_head_q[rm_lvl] == tid_ix);
            head_wd = rm_nxt;
            nx_we0  = 1'b1;
            nx_a0   = rm_prv;
            nx_d0   = rm_nxt;
            pv_we0  = 1'b1;
            pv_a0   = rm_nxt;
            pv_d0   = rm_prv;
          end
        end
      end
      FUNC_SCHED: begin
        if (!any_ready) begin
          status_d = ST_EMPTY;
        end else begin
          // Hand out the head and rotate the ring by one for round robin.
          chosen_d = sch_head;
          head_we  = 1'b1;
          head_a   = top_lvl;
          head_wd  = link_next_q[sch_head];
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q <= func_i;
      tid_q  <= thread_id_i;
      prio_q <= priority_req_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_work) begin
      status_q      <= status_d;
      next_thread_q <= TidW'(chosen_d);
    end
  end

  // State with a defined reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_mask_q <= '0;
      queued_q     <= '0;
      count_q      <= '0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        level_head_q[i] <= '0;
      end
    end else if (do_work) begin
      ready_mask_q <= ready_mask_d;
      queued_q     <= queued_d;
      count_q      <= count_d;
      if (head_we) begin
        level_head_q[head_a] <= head_wd;
      end
    end
  end

  // Link and level tables; entries are written before any read of them.
  always_ff @(posedge clk_i) begin
    if (do_work) begin
      if (lvl_we) begin
        thread_level_q[tid_ix] <= prio_ix;
      end
      if (nx_we0) begin
        link_next_q[nx_a0] <= nx_d0;
      end
      if (nx_we1) begin
        link_next_q[nx_a1] <= nx_d1;
      end
      if (pv_we0) begin
        link_prev_q[pv_a0] <= pv_d0;
      end
      if (pv_we1) begin
        link_prev_q[pv_a1] <= pv_d1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign next_thread_o = next_thread_q;

  // The count register changes only when a result is captured, so it always
  // matches the beat in the result register.
  assign ready_count_o = CountW'(count_q);

endmodule
